// ===== sv/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check that is switched off while reset is high
`define ASSERT_CLK_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// concurrent check that also holds across reset
`define ASSERT_CLK(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

// ===== sv/fbc_pkg.sv =====
// shared types and constants of the frustum box cull core
package fbc_pkg;

   localparam int COORD_BITS = 32;
   localparam int FIELD_W    = 32;
   localparam int ENTRY_W    = 32;
   localparam int FRAC_BITS  = 16;
   localparam int COMP_W     = ENTRY_W + 1;
   localparam int PROD_W     = COMP_W + COORD_BITS;
   localparam int SUM_W      = PROD_W + 2;

   localparam int MAT_DIM      = 4;
   localparam int NUM_PLANES   = 6;
   localparam int CSR_NUM_REGS = 8;
   localparam int CSR_DATA_W   = 2 * ENTRY_W;
   localparam int CSR_IDX_W    = 4;
   localparam int MAT_IDX_W    = $clog2(CSR_NUM_REGS);

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [COMP_W-1:0]     comp_type;
   typedef logic signed [PROD_W-1:0]     prod_type;
   typedef logic signed [SUM_W-1:0]      sum_type;
   typedef logic signed [ENTRY_W-1:0]    entry_type;

   typedef logic [CSR_NUM_REGS-1:0][CSR_DATA_W-1:0] mat_type;

   typedef struct packed {
      comp_type nx;
      comp_type ny;
      comp_type nz;
      comp_type d;
   } plane_type;

   typedef plane_type [NUM_PLANES-1:0] plane_arr_type;

   typedef struct packed {
      coord_type min_x;
      coord_type min_y;
      coord_type min_z;
      coord_type max_x;
      coord_type max_y;
      coord_type max_z;
   } box_type;

   // what one cell hands to the next along with its valid bit
   typedef struct packed {
      logic    vis;
      box_type box;
   } stage_type;

   // near, far, top, bottom, left, right
   localparam int unsigned PLANE_COL [NUM_PLANES] = '{2, 2, 1, 1, 0, 0};
   localparam logic        PLANE_NEG [NUM_PLANES] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};

   localparam mat_type MAT_RESET = {
      CSR_DATA_W'(64'h0001_0000_0000_0000),
      CSR_DATA_W'(64'h0),
      CSR_DATA_W'(64'h0000_0000_0001_0000),
      CSR_DATA_W'(64'h0),
      CSR_DATA_W'(64'h0),
      CSR_DATA_W'(64'h0001_0000_0000_0000),
      CSR_DATA_W'(64'h0),
      CSR_DATA_W'(64'h0000_0000_0001_0000)
   };

endpackage

// ===== sv/frustum_box_cull_core.sv =====
// frustum box cull core: a chain of six plane cells behind the matrix registers
// a request passes the product register and then the sum register of each plane cell in turn
// throughput: one box per cycle while the response is not stalled; each cell has its own multipliers, nothing shared
// back-pressure ripples per stage, so bubbles close up while a response waits
// reset: synchronous, empties the cell chain and loads the identity-like matrix
// the plane set follows a matrix write on the next cycle, no clearing pass
module frustum_box_cull_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [fbc_pkg::FIELD_W-1:0] req_min_x,
   input  logic signed [fbc_pkg::FIELD_W-1:0] req_min_y,
   input  logic signed [fbc_pkg::FIELD_W-1:0] req_min_z,
   input  logic signed [fbc_pkg::FIELD_W-1:0] req_max_x,
   input  logic signed [fbc_pkg::FIELD_W-1:0] req_max_y,
   input  logic signed [fbc_pkg::FIELD_W-1:0] req_max_z,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_visible,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [fbc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fbc_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import fbc_pkg::*;

   plane_arr_type planes;
   stage_type     link_data  [NUM_PLANES+1];
   logic          link_valid [NUM_PLANES+1];
   logic          link_ready [NUM_PLANES+1];

   fbc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .planes    (planes)
   );

   // coordinates are taken as coord_bits-wide two's complement
   always_comb begin
      link_data[0].vis       = 1'b1;
      link_data[0].box.min_x = coord_type'(req_min_x);
      link_data[0].box.min_y = coord_type'(req_min_y);
      link_data[0].box.min_z = coord_type'(req_min_z);
      link_data[0].box.max_x = coord_type'(req_max_x);
      link_data[0].box.max_y = coord_type'(req_max_y);
      link_data[0].box.max_z = coord_type'(req_max_z);
   end

   assign link_valid[0]          = req_valid;
   assign req_ready              = link_ready[0];
   assign link_ready[NUM_PLANES] = rsp_ready;

   for (genvar k = 0; k < NUM_PLANES; k++) begin : g_cell
      fbc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .plane     (planes[k]),
         .in_valid  (link_valid[k]),
         .in_ready  (link_ready[k]),
         .in_data   (link_data[k]),
         .out_valid (link_valid[k+1]),
         .out_ready (link_ready[k+1]),
         .out_data  (link_data[k+1])
      );
   end

   assign rsp_valid   = link_valid[NUM_PLANES];
   assign rsp_visible = link_data[NUM_PLANES].vis;

endmodule

// ===== sv/fbc_csr.sv =====
// matrix register file and derivation of the six clip planes
module fbc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fbc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [fbc_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output fbc_pkg::plane_arr_type              planes
);
   import fbc_pkg::*;

   mat_type   mat_ff;
   mat_type   mat_in;
   entry_type ent [MAT_DIM][MAT_DIM];

   assign csr_ready = 1'b1;

   always_comb begin
      mat_in = mat_ff;
      // writes past the last register are dropped
      if (csr_valid && (csr_index < CSR_IDX_W'(CSR_NUM_REGS))) begin
         mat_in[csr_index[MAT_IDX_W-1:0]] = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mat_ff <= MAT_RESET;
      end else begin
         mat_ff <= mat_in;
      end
   end

   // row r holds columns 0,1 in register 2r and columns 2,3 in register 2r+1
   always_comb begin
      for (int r = 0; r < MAT_DIM; r++) begin
         for (int c = 0; c < MAT_DIM; c++) begin
            ent[r][c] = mat_ff[2 * r + (c >> 1)][(c & 1) * ENTRY_W +: ENTRY_W];
         end
      end
   end

   // component i of a plane is m[i][3] plus or minus m[i][col]
   always_comb begin
      for (int p = 0; p < NUM_PLANES; p++) begin
         if (PLANE_NEG[p]) begin
            planes[p].nx = comp_type'(ent[0][3]) - comp_type'(ent[0][PLANE_COL[p]]);
            planes[p].ny = comp_type'(ent[1][3]) - comp_type'(ent[1][PLANE_COL[p]]);
            planes[p].nz = comp_type'(ent[2][3]) - comp_type'(ent[2][PLANE_COL[p]]);
            planes[p].d  = comp_type'(ent[3][3]) - comp_type'(ent[3][PLANE_COL[p]]);
         end else begin
            planes[p].nx = comp_type'(ent[0][3]) + comp_type'(ent[0][PLANE_COL[p]]);
            planes[p].ny = comp_type'(ent[1][3]) + comp_type'(ent[1][PLANE_COL[p]]);
            planes[p].nz = comp_type'(ent[2][3]) + comp_type'(ent[2][PLANE_COL[p]]);
            planes[p].d  = comp_type'(ent[3][3]) + comp_type'(ent[3][PLANE_COL[p]]);
         end
      end
   end

endmodule

// ===== sv/fbc_cell.sv =====
// one plane test cell: p-vertex select and multiply, then sum and sign
module fbc_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  fbc_pkg::plane_type    plane,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  fbc_pkg::stage_type    in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output fbc_pkg::stage_type    out_data
);
   import fbc_pkg::*;

   logic      rdy_a;
   logic      rdy_b;
   logic      vld_a_ff;
   logic      vld_b_ff;
   coord_type px;
   coord_type py;
   coord_type pz;
   prod_type  prod_x_in;
   prod_type  prod_y_in;
   prod_type  prod_z_in;
   prod_type  prod_x_ff;
   prod_type  prod_y_ff;
   prod_type  prod_z_ff;
   stage_type data_a_ff;
   stage_type data_b_in;
   stage_type data_b_ff;
   sum_type   sum;

   assign rdy_b    = !vld_b_ff || out_ready;
   assign rdy_a    = !vld_a_ff || rdy_b;
   assign in_ready = rdy_a;

   // farthest corner along the normal: max where the component is >= 0
   always_comb begin
      px = plane.nx[COMP_W-1] ? in_data.box.min_x : in_data.box.max_x;
      py = plane.ny[COMP_W-1] ? in_data.box.min_y : in_data.box.max_y;
      pz = plane.nz[COMP_W-1] ? in_data.box.min_z : in_data.box.max_z;
      prod_x_in = prod_type'(plane.nx) * prod_type'(px);
      prod_y_in = prod_type'(plane.ny) * prod_type'(py);
      prod_z_in = prod_type'(plane.nz) * prod_type'(pz);
   end

   // exact q35.32 dot product plus d scaled up by the fraction bits
   always_comb begin
      sum = sum_type'(prod_x_ff) + sum_type'(prod_y_ff) + sum_type'(prod_z_ff)
          + (sum_type'(plane.d) <<< FRAC_BITS);
      data_b_in     = data_a_ff;
      data_b_in.vis = data_a_ff.vis & ~sum[SUM_W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
      end else begin
         if (rdy_a) begin
            vld_a_ff <= in_valid;
         end
         if (rdy_b) begin
            vld_b_ff <= vld_a_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && rdy_a) begin
         prod_x_ff <= prod_x_in;
         prod_y_ff <= prod_y_in;
         prod_z_ff <= prod_z_in;
         data_a_ff <= in_data;
      end
      if (vld_a_ff && rdy_b) begin
         data_b_ff <= data_b_in;
      end
   end

   assign out_valid = vld_b_ff;
   assign out_data  = data_b_ff;

endmodule

// ===== sv/fbc_checker.sv =====
// port-level checks for the frustum box cull core and their bind
`include "assert_macros.svh"

module fbc_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_visible
);

   // a stalled response keeps its valid and its flag
   `ASSERT_CLK_RST(a_rsp_hold_valid, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)
   `ASSERT_CLK_RST(a_rsp_hold_data, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_visible))

   // the chain comes out of reset empty and open for requests
   `ASSERT_CLK(a_reset_empty, clock, reset |=> !rsp_valid && req_ready)

   // the input can only be blocked when every stage is full back to a stalled output
   `ASSERT_CLK_RST(a_block_needs_stall, clock, reset, !req_ready |-> rsp_valid && !rsp_ready)

endmodule

bind frustum_box_cull_core fbc_checker u_fbc_checker (.*);

// ===== tb/sv/tb_frustum_box_cull_core.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the frustum box cull core: directed and random boxes against several matrices
module tb_frustum_box_cull_core;

   localparam int ONE_Q16        = 1 << fbc_pkg::FRAC_BITS;
   localparam int MAT_REGS       = fbc_pkg::CSR_NUM_REGS;
   localparam int MAT_ENTRIES    = fbc_pkg::MAT_DIM * fbc_pkg::MAT_DIM;
   localparam int NUM_PHASES     = 12;
   localparam int BOXES_PER_PHASE = 105;
   localparam int MAX_WAIT       = 13;
   localparam int DRAIN_CYCLES   = 20;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int MAX_REPORTS    = 100;
   // bit p set: plane p subtracts its column (far, top, right)
   localparam logic [fbc_pkg::NUM_PLANES-1:0] PLANE_SUB = 6'b100110;

   typedef enum int {
      SET_IDENTITY,
      SET_SMALL,
      SET_ALL_MIN,
      SET_ALL_MAX,
      SET_ALL_ONES,
      SET_RANDOM,
      SET_ZERO,
      SET_NEG_D
   } matrix_setting_e;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic signed [fbc_pkg::FIELD_W-1:0] req_min_x = '0;
   logic signed [fbc_pkg::FIELD_W-1:0] req_min_y = '0;
   logic signed [fbc_pkg::FIELD_W-1:0] req_min_z = '0;
   logic signed [fbc_pkg::FIELD_W-1:0] req_max_x = '0;
   logic signed [fbc_pkg::FIELD_W-1:0] req_max_y = '0;
   logic signed [fbc_pkg::FIELD_W-1:0] req_max_z = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic                              rsp_visible;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [fbc_pkg::CSR_IDX_W-1:0]      csr_index = '0;
   logic [fbc_pkg::CSR_DATA_W-1:0]     csr_wdata = '0;

   fbc_pkg::box_type     pending_boxes [$];
   logic                 visible_expected [$];
   logic signed [31:0]   m_shadow [MAT_ENTRIES];
   logic signed [31:0]   next_m [MAT_ENTRIES];

   logic req_acc = 1'b0;
   logic rsp_acc = 1'b0;
   logic req_calm = 1'b0;
   logic rsp_calm = 1'b0;
   int   req_wait = 0;
   int   rsp_wait = 0;
   int   mismatches = 0;
   int   boxes_sent = 0;
   int   boxes_queued = 0;
   int   visible_seen = 0;
   int   culled_seen = 0;
   int   cycle_count = 0;

   frustum_box_cull_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_min_x   (req_min_x),
      .req_min_y   (req_min_y),
      .req_min_z   (req_min_z),
      .req_max_x   (req_max_x),
      .req_max_y   (req_max_y),
      .req_max_z   (req_max_z),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_visible (rsp_visible),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // p-vertex test of one box against the six planes of the shadow matrix
   function automatic logic predict_visible(fbc_pkg::box_type b);
      logic signed [127:0] acc;
      logic signed [127:0] nrm;
      logic signed [127:0] pt;
      logic signed [32:0]  ca;
      logic signed [32:0]  cb;
      logic signed [32:0]  comp [4];
      logic signed [31:0]  lo_c [3];
      logic signed [31:0]  hi_c [3];
      int                  col;
      logic                vis;
      lo_c[0] = b.min_x;
      lo_c[1] = b.min_y;
      lo_c[2] = b.min_z;
      hi_c[0] = b.max_x;
      hi_c[1] = b.max_y;
      hi_c[2] = b.max_z;
      vis = 1'b1;
      for (int p = 0; p < fbc_pkg::NUM_PLANES; p++) begin
         col = 2 - p / 2;
         for (int i = 0; i < fbc_pkg::MAT_DIM; i++) begin
            ca = m_shadow[i * 4 + 3];
            cb = m_shadow[i * 4 + col];
            comp[i] = PLANE_SUB[p] ? ca - cb : ca + cb;
         end
         acc = comp[3];
         acc = acc <<< fbc_pkg::FRAC_BITS;
         for (int i = 0; i < 3; i++) begin
            nrm = comp[i];
            // farthest corner along the normal
            pt = comp[i][32] ? lo_c[i] : hi_c[i];
            acc = acc + nrm * pt;
         end
         if (acc[127]) vis = 1'b0;
      end
      return vis;
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("mismatch at %0t: %s", $time, what);
   endtask

   // request driver
   always @(negedge clock) begin : drive_requests
      fbc_pkg::box_type nxt;
      logic             valid_next;
      valid_next = req_valid && !req_acc;
      if (reset) begin
         valid_next = 1'b0;
      end else if (!valid_next) begin
         if (req_wait > 0) begin
            req_wait--;
         end else if (pending_boxes.size() > 0) begin
            nxt = pending_boxes.pop_front();
            req_min_x <= nxt.min_x;
            req_min_y <= nxt.min_y;
            req_min_z <= nxt.min_z;
            req_max_x <= nxt.max_x;
            req_max_y <= nxt.max_y;
            req_max_z <= nxt.max_z;
            valid_next = 1'b1;
            if ($urandom_range(0, 29) == 0) req_calm = !req_calm;
            req_wait = req_calm ? 0 : $urandom_range(0, MAX_WAIT);
         end
      end
      req_valid <= valid_next;
   end

   // response stalls
   always @(negedge clock) begin
      if (rsp_acc) begin
         if ($urandom_range(0, 29) == 0) rsp_calm = !rsp_calm;
         rsp_wait = rsp_calm ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (rsp_wait > 0) begin
         rsp_wait--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // monitor: matrix shadow, predictions and response check
   always @(posedge clock) begin : monitor
      fbc_pkg::box_type cur;
      logic             want;
      int               row;
      if (reset) begin
         req_acc <= 1'b0;
         rsp_acc <= 1'b0;
         for (int k = 0; k < MAT_ENTRIES; k++) m_shadow[k] = (k % 5 == 0) ? ONE_Q16 : 0;
      end else begin
         req_acc <= req_valid && req_ready;
         rsp_acc <= rsp_valid && rsp_ready;
         if (csr_valid && csr_ready && csr_index < MAT_REGS) begin
            row = csr_index >> 1;
            m_shadow[row * 4 + csr_index[0] * 2]     = csr_wdata[31:0];
            m_shadow[row * 4 + csr_index[0] * 2 + 1] = csr_wdata[63:32];
         end
         if (req_valid && req_ready) begin
            cur.min_x = req_min_x;
            cur.min_y = req_min_y;
            cur.min_z = req_min_z;
            cur.max_x = req_max_x;
            cur.max_y = req_max_y;
            cur.max_z = req_max_z;
            visible_expected.push_back(predict_visible(cur));
            boxes_sent++;
         end
         if (rsp_valid && rsp_ready) begin
            if (visible_expected.size() == 0) begin
               report_mismatch("response with no request outstanding");
            end else begin
               want = visible_expected.pop_front();
               if (rsp_visible !== want)
                  report_mismatch($sformatf("visible got %b expected %b", rsp_visible, want));
            end
            if (rsp_visible === 1'b1) visible_seen++;
            else culled_seen++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d requests outstanding", cycle_count,
                  visible_expected.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic write_csr(input logic [fbc_pkg::CSR_IDX_W-1:0] idx,
                            input logic [fbc_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_index <= idx;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic push_box(input logic signed [31:0] mnx, input logic signed [31:0] mny,
                           input logic signed [31:0] mnz, input logic signed [31:0] mxx,
                           input logic signed [31:0] mxy, input logic signed [31:0] mxz);
      fbc_pkg::box_type b;
      b.min_x = mnx;
      b.min_y = mny;
      b.min_z = mnz;
      b.max_x = mxx;
      b.max_y = mxy;
      b.max_z = mxz;
      pending_boxes.push_back(b);
      boxes_queued++;
   endtask

   function automatic logic signed [31:0] near_coord();
      int v;
      v = $urandom_range(0, 6 * ONE_Q16);
      return v - 3 * ONE_Q16;
   endfunction

   function automatic logic signed [31:0] extreme_coord();
      case ($urandom_range(0, 6))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 0;
         3: return -1;
         4: return ONE_Q16;
         5: return -ONE_Q16;
         default: return 1;
      endcase
   endfunction

   task automatic push_random_box();
      logic signed [31:0] a [6];
      logic signed [31:0] t;
      int                 kind;
      kind = $urandom_range(0, 9);
      for (int k = 0; k < 6; k++) begin
         case (kind)
            7: a[k] = $urandom;
            8: a[k] = extreme_coord();
            default: a[k] = near_coord();
         endcase
      end
      if (kind == 9) begin
         // degenerate box: a single point
         for (int k = 0; k < 3; k++) a[k + 3] = a[k];
      end else if (kind <= 5) begin
         for (int k = 0; k < 3; k++) begin
            if (a[k] > a[k + 3]) begin
               t = a[k];
               a[k] = a[k + 3];
               a[k + 3] = t;
            end
         end
      end
      push_box(a[0], a[1], a[2], a[3], a[4], a[5]);
   endtask

   task automatic program_matrix(input matrix_setting_e setting);
      int row;
      int c0;
      for (int k = 0; k < MAT_ENTRIES; k++) begin
         case (setting)
            SET_IDENTITY: next_m[k] = (k % 5 == 0) ? ONE_Q16 : 0;
            SET_SMALL:    next_m[k] = $urandom_range(0, 3 * ONE_Q16) - 3 * ONE_Q16 / 2;
            SET_ALL_MIN:  next_m[k] = 32'h8000_0000;
            SET_ALL_MAX:  next_m[k] = 32'h7fff_ffff;
            SET_ALL_ONES: next_m[k] = 32'hffff_ffff;
            SET_RANDOM:   next_m[k] = $urandom;
            SET_ZERO:     next_m[k] = 0;
            // zero normals, negative offset: every box is culled
            SET_NEG_D:    next_m[k] = (k == MAT_ENTRIES - 1) ? -$urandom_range(1, ONE_Q16) : 0;
            default:      next_m[k] = 0;
         endcase
      end
      for (int r = 0; r < MAT_REGS; r++) begin
         row = r / 2;
         c0 = (r % 2) * 2;
         write_csr(fbc_pkg::CSR_IDX_W'(r), {next_m[row * 4 + c0 + 1], next_m[row * 4 + c0]});
      end
   endtask

   function automatic matrix_setting_e setting_for(int ph);
      case (ph)
         1, 3, 10: return SET_SMALL;
         2:        return SET_ALL_MIN;
         4:        return SET_ALL_MAX;
         5, 9:     return SET_RANDOM;
         6:        return SET_ZERO;
         7:        return SET_ALL_ONES;
         8:        return SET_NEG_D;
         default:  return SET_IDENTITY;
      endcase
   endfunction

   initial begin : stimulus
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // writes past the last matrix register must leave the matrix alone
      write_csr(fbc_pkg::CSR_IDX_W'(MAT_REGS + $urandom_range(0, MAT_REGS - 1)),
                {$urandom, $urandom});
      // reset matrix bounds the cube [-1, 1] on every axis
      push_box(-ONE_Q16 / 2, -ONE_Q16 / 2, -ONE_Q16 / 2, ONE_Q16 / 2, ONE_Q16 / 2, ONE_Q16 / 2);
      push_box(-2 * ONE_Q16, 0, 0, -ONE_Q16, 0, 0);
      push_box(-2 * ONE_Q16, 0, 0, -ONE_Q16 - 1, 0, 0);
      push_box(ONE_Q16, 0, 0, 2 * ONE_Q16, 0, 0);
      push_box(ONE_Q16 + 1, 0, 0, 2 * ONE_Q16, 0, 0);
      push_box(0, -2 * ONE_Q16, 0, 0, -ONE_Q16, 0);
      push_box(0, ONE_Q16 + 1, 0, 0, 2 * ONE_Q16, 0);
      push_box(0, 0, ONE_Q16, 0, 0, 2 * ONE_Q16);
      push_box(0, 0, -2 * ONE_Q16, 0, 0, -ONE_Q16 - 1);
      // inverted boxes are taken as given
      push_box(2 * ONE_Q16, 0, 0, -2 * ONE_Q16, 0, 0);
      push_box(ONE_Q16 / 2, ONE_Q16 / 2, 0, -ONE_Q16 / 2, -ONE_Q16 / 2, 0);
      push_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      push_box(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
               32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      push_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      push_box(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
               32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      push_box(0, 0, 0, 0, 0, 0);
      push_box(-1, -1, -1, -1, -1, -1);
      push_box(-ONE_Q16, -ONE_Q16, -ONE_Q16, ONE_Q16, ONE_Q16, ONE_Q16);
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         if (ph > 0) begin
            program_matrix(setting_for(ph));
            write_csr(fbc_pkg::CSR_IDX_W'(MAT_REGS + $urandom_range(0, MAT_REGS - 1)),
                      {$urandom, $urandom});
         end
         for (int n = 0; n < BOXES_PER_PHASE; n++) push_random_box();
         // wait until every queued box has come back
         while (visible_seen + culled_seen < boxes_queued) @(negedge clock);
         repeat (DRAIN_CYCLES) @(negedge clock);
      end
      $display("covered %0d boxes over %0d matrix settings with random request gaps and stalls",
               boxes_sent, NUM_PHASES);
      $display("responses: %0d visible, %0d culled, %0d mismatches",
               visible_seen, culled_seen, mismatches);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
